// ----- design/sorpq_pkg.sv -----
// ----------------------------------------------------------------------------
// sorpq_pkg
// Shared types and codes for the sorted priority queue cell chain.
// ----------------------------------------------------------------------------
package sorpq_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned PriW = 8;

  // request codes
  localparam logic ReqEnq = 1'b0;
  localparam logic ReqDeq = 1'b1;

  // result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ENQ,
    OP_DEQ
  } cell_op_t;

  // broadcast control from the top level to the cell chain
  typedef struct packed {
    cell_op_t          op;
    logic [ValW-1:0]   new_val;
    logic [PriW-1:0]   new_pri;
  } cell_ctrl_t;

endpackage

// ----- design/sorted_priority_queue_top.sv -----
// Sorted priority queue: a chain of QUEUE_DEPTH cells, all compared in parallel.
// The result is registered: it shows in the cycle after its request is accepted.
// Throughput: 1 request per cycle if results are taken; one compare-and-shift.
// Reset (rst_n, synchronous): count and result valid clear; slot contents are
// left as they are and are only read below the count.
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Request decode, fill count, result register and the cell chain.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import sorpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  logic signed [ValW-1:0]  in_item_value,
  input  logic [PriW-1:0]         in_item_priority,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ValW-1:0]  out_value,
  output logic [PriW-1:0]         out_priority,
  output logic [1:0]              out_status,
  output logic [4:0]              out_entry_count
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0] count_r, count_nxt;
  logic            out_valid_r;
  logic [ValW-1:0] res_val_r, res_val_nxt;
  logic [PriW-1:0] res_pri_r, res_pri_nxt;
  logic [1:0]      res_st_r, res_st_nxt;
  logic            accept;
  logic            is_full, is_empty;
  cell_ctrl_t      ctrl;

  logic [ValW-1:0] cell_val [QUEUE_DEPTH];
  logic [PriW-1:0] cell_pri [QUEUE_DEPTH];
  logic            cell_ge  [QUEUE_DEPTH];
  logic [CntW+4:0] count_ext;

  // handshake: the result register frees up when its beat is taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == Depth);
  assign is_empty = (count_r == '0);

  // request decode into the cell operation and the result
  always_comb begin
    ctrl.op      = OP_HOLD;
    ctrl.new_val = in_item_value;
    ctrl.new_pri = in_item_priority;
    count_nxt    = count_r;
    res_val_nxt  = '0;
    res_pri_nxt  = '0;
    res_st_nxt   = StOk;
    if (in_req_type == ReqEnq) begin
      if (is_full) begin
        res_st_nxt = StFull;
      end else begin
        ctrl.op   = accept ? OP_ENQ : OP_HOLD;
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        res_st_nxt = StEmpty;
      end else begin
        ctrl.op     = accept ? OP_DEQ : OP_HOLD;
        count_nxt   = count_r - 1'b1;
        res_val_nxt = cell_val[0];
        res_pri_nxt = cell_pri[0];
      end
    end
  end

  // count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_val_r <= res_val_nxt;
      res_pri_r <= res_pri_nxt;
      res_st_r  <= res_st_nxt;
    end
  end

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            occ;
    logic            lge;
    logic [ValW-1:0] lval, rval;
    logic [PriW-1:0] lpri, rpri;

    assign occ = (CntW'(i) < count_r);

    if (i == 0) begin : g_head
      assign lge  = 1'b1;
      assign lval = '0;
      assign lpri = '0;
    end else begin : g_mid
      assign lge  = cell_ge[i-1];
      assign lval = cell_val[i-1];
      assign lpri = cell_pri[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rval = '0;
      assign rpri = '0;
    end else begin : g_body
      assign rval = cell_val[i+1];
      assign rpri = cell_pri[i+1];
    end

    sorpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .left_ge   (lge),
      .left_val  (lval),
      .left_pri  (lpri),
      .right_val (rval),
      .right_pri (rpri),
      .ge        (cell_ge[i]),
      .val       (cell_val[i]),
      .pri       (cell_pri[i])
    );
  end

  // outputs; count reported modulo 32
  assign count_ext       = {5'b0, count_r};
  assign out_valid       = out_valid_r;
  assign out_value       = res_val_r;
  assign out_priority    = res_pri_r;
  assign out_status      = res_st_r;
  assign out_entry_count = count_ext[4:0];

`ifndef SYNTHESIS
  // count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Depth)
    else $error("fill count above depth");

  // an empty dequeue leaves the queue empty
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == ReqDeq && is_empty) |=> (count_r == '0))
    else $error("dequeue on empty changed count");

  // a full enqueue is dropped without changing the count
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == ReqEnq && is_full) |=> (count_r == Depth))
    else $error("enqueue on full changed count");

  // head stays sorted against its neighbor
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CntW'(2)) |-> (cell_pri[0] <= cell_pri[1]))
    else $error("head entry out of order");
`endif

endmodule

// ----- design/sorpq_cell.sv -----
// ----------------------------------------------------------------------------
// sorpq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts from
// a neighbor depending on the broadcast operation and a local compare.
// ----------------------------------------------------------------------------
module sorpq_cell
  import sorpq_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              occupied,
  input  logic              left_ge,
  input  logic [ValW-1:0]   left_val,
  input  logic [PriW-1:0]   left_pri,
  input  logic [ValW-1:0]   right_val,
  input  logic [PriW-1:0]   right_pri,
  output logic              ge,
  output logic [ValW-1:0]   val,
  output logic [PriW-1:0]   pri
);

  logic [ValW-1:0] val_r, val_nxt;
  logic [PriW-1:0] pri_r, pri_nxt;

  // entry stays ahead of the new one when occupied and its priority is not larger
  assign ge = occupied && (pri_r <= ctrl.new_pri);

  // slot update
  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    case (ctrl.op)
      OP_ENQ: begin
        if (!ge) begin
          if (left_ge) begin
            val_nxt = ctrl.new_val;
            pri_nxt = ctrl.new_pri;
          end else begin
            val_nxt = left_val;
            pri_nxt = left_pri;
          end
        end
      end
      OP_DEQ: begin
        val_nxt = right_val;
        pri_nxt = right_pri;
      end
      default: begin
        val_nxt = val_r;
        pri_nxt = pri_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

  assign val = val_r;
  assign pri = pri_r;

endmodule

// ----- tb/sorted_priority_queue_top_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Sends enqueue and dequeue beats into the sorted priority queue. A shadow
// copy of the sorted store predicts each result beat, which is then compared
// field by field. Both sides idle and stall at random during most of the run.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb
  import sorpq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth         = 16;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned NumPhases     = 14;
  localparam int unsigned PhaseItems    = 40;

  typedef struct {
    logic signed [ValW-1:0] val;
    logic [PriW-1:0]        pri;
    logic [1:0]             status;
    logic [4:0]             count;
  } queue_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_req_type;
  logic signed [ValW-1:0] in_item_value;
  logic [PriW-1:0]        in_item_priority;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [ValW-1:0] out_value;
  logic [PriW-1:0]        out_priority;
  logic [1:0]             out_status;
  logic [4:0]             out_entry_count;

  // shadow of the sorted store
  logic signed [ValW-1:0] shadow_val [Depth];
  logic [PriW-1:0]        shadow_pri [Depth];
  int unsigned            shadow_count = 0;

  queue_result_t pending_results[$];
  int unsigned   error_count = 0;

  // pacing knobs for the sender and the receiver
  int unsigned burst_left   = 0;
  int unsigned gap_max      = 0;
  int unsigned stall_pct    = 0;
  bit          hold_off_req = 1'b0;

  sorted_priority_queue_top #(
    .QUEUE_DEPTH(Depth)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  // apply one request to the shadow store and return the result it gives
  function automatic queue_result_t apply_request(logic req, logic signed [ValW-1:0] val,
                                                  logic [PriW-1:0] pri);
    queue_result_t res;
    int unsigned   slot;
    int unsigned   k;
    res.val    = '0;
    res.pri    = '0;
    res.status = StOk;
    if (req == ReqEnq) begin
      if (shadow_count >= Depth) begin
        res.status = StFull;
      end else begin
        // new entry goes after every entry with a lower or equal number
        slot = 0;
        while (slot < shadow_count && shadow_pri[slot] <= pri) slot++;
        for (k = shadow_count; k > slot; k--) begin
          shadow_val[k] = shadow_val[k-1];
          shadow_pri[k] = shadow_pri[k-1];
        end
        shadow_val[slot] = val;
        shadow_pri[slot] = pri;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = StEmpty;
    end else begin
      // pop the head and close the gap
      res.val = shadow_val[0];
      res.pri = shadow_pri[0];
      for (k = 0; k + 1 < shadow_count; k++) begin
        shadow_val[k] = shadow_val[k+1];
        shadow_pri[k] = shadow_pri[k+1];
      end
      shadow_count--;
    end
    res.count = 5'(shadow_count);
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // one request beat; called at a rising edge, returns at the accepting edge
  task automatic send_request(logic req, logic signed [ValW-1:0] val, logic [PriW-1:0] pri);
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_item_value    <= val;
    in_item_priority <= pri;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    pending_results.push_back(apply_request(req, val, pri));
    @(posedge clk);
  endtask

  // request beat inside a burst, with a random gap once a burst runs out
  task automatic send_paced(logic req, logic signed [ValW-1:0] val, logic [PriW-1:0] pri);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_request(req, val, pri);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // empty dequeue, head insertion, ties kept in arrival order, field extremes
  task automatic test_empty_and_ordering();
    gap_max   = 3;
    stall_pct = 30;
    send_paced(ReqDeq, 32'sh7fffffff, 8'hff);
    send_paced(ReqEnq, 32'sh7fffffff, 8'hff);
    send_paced(ReqEnq, 32'sh80000000, 8'h00);
    send_paced(ReqEnq, 32'sh00000001, 8'h80);
    send_paced(ReqEnq, -32'sd1, 8'h80);
    send_paced(ReqEnq, 32'sh00000000, 8'h00);
    repeat (5) send_paced(ReqDeq, 32'sh80000000, 8'h00);
    send_paced(ReqDeq, -32'sd1, 8'hff);
    wait_results_drained();
  endtask

  // long receiver hold-off while enqueues keep coming: fills, drops, then drains
  task automatic test_fill_under_backpressure();
    gap_max      = 0;
    burst_left   = 0;
    hold_off_req = 1'b1;
    repeat (Depth + 4) send_paced(ReqEnq, $urandom, 8'($urandom_range(0, 255)));
    wait_results_drained();
    gap_max   = 4;
    stall_pct = 20;
    repeat (Depth + 4) send_paced(ReqDeq, $urandom, 8'($urandom_range(0, 255)));
    wait_results_drained();
  endtask

  // phases alternate between filling and draining; one phase in three uses narrow priorities
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned enq_pct;
    bit          narrow;
    logic        req;
    for (phase = 0; phase < NumPhases; phase++) begin
      enq_pct = (phase % 2 == 0) ? 75 : 30;
      narrow  = (phase % 3 == 1);
      case (phase % 4)
        0: begin gap_max = 0; stall_pct = 0; end
        1: begin gap_max = 3; stall_pct = 25; end
        2: begin gap_max = 8; stall_pct = 60; end
        default: begin gap_max = 2; stall_pct = 10; end
      endcase
      for (n = 0; n < PhaseItems; n++) begin
        req = ($urandom_range(0, 99) < enq_pct) ? ReqEnq : ReqDeq;
        send_paced(req, $urandom,
                   narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)));
      end
    end
    wait_results_drained();
  endtask

  // result receiver: random ready runs, plus a long hold-off on request
  initial begin
    int unsigned run_left;
    int unsigned held;
    logic        ready_now;
    run_left  = 0;
    ready_now = 1'b1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < HoldOffCycles; held++) @(posedge clk);
        hold_off_req = 1'b0;
        run_left     = 0;
      end else begin
        if (run_left == 0) begin
          ready_now = ($urandom_range(0, 99) >= stall_pct);
          run_left  = $urandom_range(1, 8);
        end
        run_left--;
        out_ready <= ready_now;
      end
    end
  end

  // result checker: sampled mid-cycle, the beat completes at the next edge
  always @(negedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got value %0h status %0d",
                 $time, out_value, out_status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("value", want.val, out_value);
        compare_field("priority", 32'(want.pri), 32'(out_priority));
        compare_field("status", 32'(want.status), 32'(out_status));
        compare_field("entry_count", 32'(want.count), 32'(out_entry_count));
      end
    end
  end

  // main sequence
  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_req_type      <= ReqEnq;
    in_item_value    <= '0;
    in_item_priority <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_ordering();
    test_fill_under_backpressure();
    test_random_traffic();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/sorpq_pkg.sv
design/sorpq_cell.sv
design/sorted_priority_queue_top.sv
tb/sorted_priority_queue_top_tb.sv
